### rtl/bdq_pkg.sv
// shared types and constants for the bounded deque with search and delete
// no dependencies; used by bdq_ctrl, bdq_out and the top level by scoped names
`timescale 1ns / 1ps

package bdq_pkg;

  // store geometry
  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // field widths of the stream items
  localparam int ACTION_W      = 3;
  localparam int KEY_W         = 32;
  localparam int STATUS_W      = 2;
  localparam int ENTRY_COUNT_W = 5;
  localparam int IN_TDATA_W    = 40;
  localparam int OUT_TDATA_W   = 40;

  // action codes carried in the input transaction
  typedef enum logic [ACTION_W-1:0] {
    ACT_SEARCH    = 3'd0,
    ACT_INS_FRONT = 3'd1,
    ACT_INS_END   = 3'd2,
    ACT_REM_FRONT = 3'd3,
    ACT_REM_END   = 3'd4,
    ACT_REM_VALUE = 3'd5
  } action_t;

  // status codes returned with each result
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  // one result item
  typedef struct packed {
    status_t                    status;
    logic                       found;
    logic [KEY_W-1:0]           removed_value;
    logic [ENTRY_COUNT_W-1:0]   entry_count;
  } result_t;

  // access request from the sequencer to the entry store
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [KEY_W-1:0] wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

endpackage

### rtl/bdq_ram.sv
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
`timescale 1ns / 1ps

module bdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/bdq_ctrl.sv
// sequencer: decodes actions, keeps head and count, scans and closes up the store
// depends on bdq_pkg; drives the entry ram through a request struct
`timescale 1ns / 1ps

module bdq_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  // incoming action
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bdq_pkg::ACTION_W-1:0]  in_action,
  input  logic [bdq_pkg::KEY_W-1:0]     in_key,
  // entry store
  output bdq_pkg::mem_req_t             mem_req,
  input  logic [bdq_pkg::KEY_W-1:0]     mem_rdata,
  // finished result
  output logic                          res_valid,
  input  logic                          res_ready,
  output bdq_pkg::result_t              res
);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_SCAN_RD  = 8'b0000_0010,
    S_SCAN_CMP = 8'b0000_0100,
    S_SHIFT_RD = 8'b0000_1000,
    S_SHIFT_WR = 8'b0001_0000,
    S_POP_DATA = 8'b0010_0000,
    S_DONE     = 8'b0100_0000
  } state_t;

  state_t                        state, state_next;
  logic [bdq_pkg::IDX_W-1:0]     head, head_next;
  logic [bdq_pkg::CNT_W-1:0]     count, count_next;
  logic [bdq_pkg::CNT_W-1:0]     idx, idx_next;
  bdq_pkg::action_t              act, act_next;
  logic [bdq_pkg::KEY_W-1:0]     key, key_next;
  bdq_pkg::status_t              status, status_next;
  logic                          found, found_next;
  logic [bdq_pkg::KEY_W-1:0]     removed, removed_next;
  logic                          accept;
  logic                          is_full;
  logic                          is_empty;
  logic [bdq_pkg::IDX_W-1:0]     head_dec;
  logic [bdq_pkg::IDX_W-1:0]     head_inc;

  // logical position to physical slot of the circular store
  function automatic logic [bdq_pkg::IDX_W-1:0] phys(
    input logic [bdq_pkg::IDX_W-1:0] h,
    input logic [bdq_pkg::CNT_W-1:0] l
  );
    logic [bdq_pkg::CNT_W:0] s;
    s = (bdq_pkg::CNT_W + 1)'(h) + (bdq_pkg::CNT_W + 1)'(l);
    if (s >= (bdq_pkg::CNT_W + 1)'(bdq_pkg::CAPACITY)) begin
      s = s - (bdq_pkg::CNT_W + 1)'(bdq_pkg::CAPACITY);
    end
    return s[bdq_pkg::IDX_W-1:0];
  endfunction

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign res_valid = (state == S_DONE);
  assign is_full   = (count == bdq_pkg::CNT_W'(bdq_pkg::CAPACITY));
  assign is_empty  = (count == '0);

  // head moves with wrap at the store size
  assign head_dec = (head == '0) ? bdq_pkg::IDX_W'(bdq_pkg::CAPACITY - 1)
                                 : head - 1'b1;
  assign head_inc = (head == bdq_pkg::IDX_W'(bdq_pkg::CAPACITY - 1)) ? '0
                                 : head + 1'b1;

  // result fields
  assign res.status        = status;
  assign res.found         = found;
  assign res.removed_value = removed;
  assign res.entry_count   = bdq_pkg::ENTRY_COUNT_W'(count);

  // sequencer next state and store accesses
  always_comb begin
    state_next   = state;
    head_next    = head;
    count_next   = count;
    idx_next     = idx;
    act_next     = act;
    key_next     = key;
    status_next  = status;
    found_next   = found;
    removed_next = removed;
    mem_req      = '0;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          act_next     = bdq_pkg::action_t'(in_action);
          key_next     = in_key;
          status_next  = bdq_pkg::ST_OK;
          found_next   = 1'b0;
          removed_next = '0;
          idx_next     = '0;
          state_next   = S_DONE;
          unique case (bdq_pkg::action_t'(in_action))
            bdq_pkg::ACT_SEARCH: begin
              if (!is_empty) begin
                state_next = S_SCAN_RD;
              end
            end
            bdq_pkg::ACT_REM_VALUE: begin
              if (is_empty) begin
                status_next = bdq_pkg::ST_NOTFOUND;
              end else begin
                state_next = S_SCAN_RD;
              end
            end
            bdq_pkg::ACT_INS_FRONT: begin
              if (is_full) begin
                status_next = bdq_pkg::ST_FULL;
              end else begin
                mem_req.we    = 1'b1;
                mem_req.waddr = head_dec;
                mem_req.wdata = in_key;
                head_next     = head_dec;
                count_next    = count + 1'b1;
              end
            end
            bdq_pkg::ACT_INS_END: begin
              if (is_full) begin
                status_next = bdq_pkg::ST_FULL;
              end else begin
                mem_req.we    = 1'b1;
                mem_req.waddr = phys(head, count);
                mem_req.wdata = in_key;
                count_next    = count + 1'b1;
              end
            end
            bdq_pkg::ACT_REM_FRONT: begin
              if (is_empty) begin
                status_next = bdq_pkg::ST_EMPTY;
              end else begin
                mem_req.re    = 1'b1;
                mem_req.raddr = head;
                state_next    = S_POP_DATA;
              end
            end
            bdq_pkg::ACT_REM_END: begin
              if (is_empty) begin
                status_next = bdq_pkg::ST_EMPTY;
              end else begin
                mem_req.re    = 1'b1;
                mem_req.raddr = phys(head, count - 1'b1);
                state_next    = S_POP_DATA;
              end
            end
            default: begin
              // unused codes: nothing changes
            end
          endcase
        end
      end

      S_POP_DATA: begin
        removed_next = mem_rdata;
        count_next   = count - 1'b1;
        if (act == bdq_pkg::ACT_REM_FRONT) begin
          head_next = head_inc;
        end
        state_next = S_DONE;
      end

      S_SCAN_RD: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = phys(head, idx);
        state_next    = S_SCAN_CMP;
      end

      S_SCAN_CMP: begin
        if (mem_rdata == key) begin
          found_next = 1'b1;
          if (act == bdq_pkg::ACT_SEARCH) begin
            state_next = S_DONE;
          end else if ((idx + 1'b1) < count) begin
            state_next = S_SHIFT_RD;
          end else begin
            // match on the last entry: nothing to close up
            count_next = count - 1'b1;
            state_next = S_DONE;
          end
        end else if ((idx + 1'b1) == count) begin
          if (act == bdq_pkg::ACT_REM_VALUE) begin
            status_next = bdq_pkg::ST_NOTFOUND;
          end
          state_next = S_DONE;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = S_SCAN_RD;
        end
      end

      S_SHIFT_RD: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = phys(head, idx + 1'b1);
        state_next    = S_SHIFT_WR;
      end

      S_SHIFT_WR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = phys(head, idx);
        mem_req.wdata = mem_rdata;
        idx_next      = idx + 1'b1;
        if ((idx + 2'd2) < count) begin
          state_next = S_SHIFT_RD;
        end else begin
          count_next = count - 1'b1;
          state_next = S_DONE;
        end
      end

      S_DONE: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    idx     <= idx_next;
    act     <= act_next;
    key     <= key_next;
    status  <= status_next;
    found   <= found_next;
    removed <= removed_next;
  end

endmodule

### rtl/bdq_out.sv
// output register between the sequencer and the result stream
// depends on bdq_pkg for the result struct
`timescale 1ns / 1ps

module bdq_out (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  bdq_pkg::result_t in_res,
  output logic             out_valid,
  input  logic             out_ready,
  output bdq_pkg::result_t out_res
);

  logic full;

  assign in_ready  = !full || out_ready;
  assign out_valid = full;

  // occupancy of the holding register
  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (in_valid && in_ready) begin
      full <= 1'b1;
    end else if (out_ready) begin
      full <= 1'b0;
    end
  end

  // held result
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_res <= in_res;
    end
  end

endmodule

### rtl/bounded_deque_with_search_delete.sv
// top level of the bounded deque with search and delete
// depends on bdq_pkg, bdq_ram, bdq_ctrl and bdq_out
`timescale 1ns / 1ps
//
//  channel   | dir | tdata (low bit up)                               | tuser/tlast
//  ----------+-----+--------------------------------------------------+------------
//  s_axis    | in  | action[2:0], key_value[34:3], zero pad           | none
//  m_axis    | out | status[1:0], found[2], removed_value[34:3],      | none
//            |     | entry_count[39:35]                               |
//
//  one action at a time; entries sit in a circular ram with a registered read port
//  inserts write as taken; errors skip the store; front/end removals read, then pop
//  search reads, then compares, each entry; value removal moves each later one up
//  reset empties the deque at once; the ram contents need no clearing
//  a waiting result sits in the output register, so the next action may start meanwhile

module bounded_deque_with_search_delete (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // action[2:0], key_value[34:3], zero pad[39:35]
  input  logic [bdq_pkg::IN_TDATA_W-1:0]   s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // status[1:0], found[2], removed_value[34:3], entry_count[39:35]
  output logic [bdq_pkg::OUT_TDATA_W-1:0]  m_tdata
);

  bdq_pkg::mem_req_t             mem_req;
  logic [bdq_pkg::KEY_W-1:0]     mem_rdata;
  logic                          res_valid;
  logic                          res_ready;
  bdq_pkg::result_t              res;
  bdq_pkg::result_t              out_res;

  // sequencer
  bdq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_action (s_tdata[bdq_pkg::ACTION_W-1:0]),
    .in_key    (s_tdata[bdq_pkg::ACTION_W +: bdq_pkg::KEY_W]),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // entry store
  bdq_ram #(
    .WIDTH (bdq_pkg::KEY_W),
    .DEPTH (bdq_pkg::CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

  // result holding register
  bdq_out u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (res_valid),
    .in_ready  (res_ready),
    .in_res    (res),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

  // pack the result transaction
  assign m_tdata = {out_res.entry_count, out_res.removed_value,
                    out_res.found, out_res.status};

endmodule
